// ----- rtl/smbs_pkg.sv -----
`default_nettype none

package smbs_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned TIMER_W       = 18;
    localparam int unsigned CNT_W         = 4;

    localparam logic [15:0]        HALF_PERIOD_RESET = 16'd250;
    localparam logic [CNT_W-1:0]   BIT_LIMIT         = CNT_W'(BITS_PER_BYTE);

    typedef struct packed {
        logic       sclk_level;
        logic       mosi_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } smbs_res_t;

endpackage

`default_nettype wire

// ----- rtl/smbs_channels.sv -----
`default_nettype none

interface smbs_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] tx_byte;
    logic       msb_first;
    logic       miso_level;

    modport source (output valid, output start_req, output tx_byte, output msb_first,
                    output miso_level, input ready);
    modport sink   (input valid, input start_req, input tx_byte, input msb_first,
                    input miso_level, output ready);
endinterface

interface smbs_out_if;
    logic       valid;
    logic       ready;
    logic       sclk_level;
    logic       mosi_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;

    modport source (output valid, output sclk_level, output mosi_level, output busy_res,
                    output done_res, output rx_byte, input ready);
    modport sink   (input valid, input sclk_level, input mosi_level, input busy_res,
                    input done_res, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/smbs_engine.sv -----
`default_nettype none

module smbs_engine
    import smbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        beat_acc,
    input  wire logic        start_req,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        msb_first,
    input  wire logic        miso_level,
    output smbs_res_t        res
);

    typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_TAIL} phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [7:0]         tx_reg, tx_next;
    logic [7:0]         rx_reg, rx_next;
    logic               order_reg, order_next;
    logic [15:0]        half_reg;

    logic               start;
    phase_t             cur_phase;
    logic [CNT_W-1:0]   cur_cnt;
    logic [TIMER_W-1:0] cur_timer, timer_inc, limit;
    logic [7:0]         cur_tx, cur_rx;
    logic               cur_order, cur_bit, over;
    logic [15:0]        half_eff;
    logic [CNT_W-1:0]   cnt_inc;

    assign half_eff  = (half_reg == 16'd0) ? 16'd1 : half_reg;
    assign start     = (phase_reg == PH_IDLE) && start_req;
    assign cur_phase = start ? PH_HIGH : phase_reg;
    assign cur_cnt   = start ? '0 : cnt_reg;
    assign cur_timer = start ? '0 : timer_reg;
    assign cur_tx    = start ? tx_byte : tx_reg;
    assign cur_rx    = start ? 8'd0 : rx_reg;
    assign cur_order = start ? msb_first : order_reg;
    assign cur_bit   = cur_order ? cur_tx[7] : cur_tx[0];
    assign timer_inc = cur_timer + TIMER_W'(1);
    assign limit     = (cur_phase == PH_TAIL) ? {half_eff, 2'b00} : {2'b00, half_eff};
    assign over      = (timer_inc >= limit);
    assign cnt_inc   = cur_cnt + CNT_W'(1);

    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt;
        timer_next = cur_timer;
        tx_next    = cur_tx;
        rx_next    = cur_rx;
        order_next = cur_order;
        res        = '0;
        unique case (cur_phase)
            PH_HIGH:
            begin
                res.sclk_level = 1'b1;
                res.mosi_level = cur_bit;
                res.busy_res   = 1'b1;
                timer_next     = over ? '0 : timer_inc;
                if (over)
                begin
                    rx_next    = cur_order ? {cur_rx[6:0], miso_level}
                                           : {miso_level, cur_rx[7:1]};
                    phase_next = PH_LOW;
                end
            end
            PH_LOW:
            begin
                res.mosi_level = cur_bit;
                res.busy_res   = 1'b1;
                timer_next     = over ? '0 : timer_inc;
                if (over)
                begin
                    tx_next    = cur_order ? {cur_tx[6:0], 1'b0} : {1'b0, cur_tx[7:1]};
                    cnt_next   = cnt_inc;
                    phase_next = (cnt_inc >= BIT_LIMIT) ? PH_TAIL : PH_HIGH;
                end
            end
            PH_TAIL:
            begin
                res.busy_res = 1'b1;
                timer_next   = over ? '0 : timer_inc;
                if (over)
                begin
                    res.done_res = 1'b1;
                    res.rx_byte  = cur_rx;
                    phase_next   = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            timer_reg <= '0;
            tx_reg    <= '0;
            rx_reg    <= '0;
            order_reg <= 1'b0;
            half_reg  <= HALF_PERIOD_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                half_reg <= cfg_wr_data;
            end
            if (beat_acc)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                timer_reg <= timer_next;
                tx_reg    <= tx_next;
                rx_reg    <= rx_next;
                order_reg <= order_next;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= BIT_LIMIT)
        else $error("bit count beyond byte length");

    a_tail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAIL) |-> (cnt_reg == BIT_LIMIT))
        else $error("tail gap entered before last bit");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_acc && phase_reg == PH_IDLE && !start_req) |-> (res == '0))
        else $error("idle beat drives nonzero result");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_acc && res.done_res) |=> (phase_reg == PH_IDLE))
        else $error("done without return to idle");

endmodule

`default_nettype wire

// ----- rtl/smbs_out_buf.sv -----
`default_nettype none

module smbs_out_buf
    import smbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire smbs_res_t push_data,
    output logic           push_ready,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output smbs_res_t      pop_data
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    smbs_res_t main_reg;
    smbs_res_t skid_reg;
    logic      pop;

    assign pop        = main_valid_reg && pop_ready;
    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                main_valid_reg <= 1'b1;
                if (main_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty main entry");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("beat pushed into full buffer");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && main_reg == $past(skid_reg)))
        else $error("skid entry lost on drain");

endmodule

`default_nettype wire

// ----- rtl/spi_master_byte_shifter.sv -----
// A result beat is registered in the output buffer when its input beat is accepted.
// Throughput: one input beat per cycle; input ready drops only while the
// two-entry output buffer is full behind a stalled sink.
// Reset (rst_n, async, active low): engine idle, half period 250 ticks,
// output buffer empty.
`default_nettype none

module spi_master_byte_shifter
    import smbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    smbs_in_if.sink          in_ch,
    smbs_out_if.source       out_ch
);

    logic      beat_acc;
    logic      buf_ready;
    smbs_res_t res;
    smbs_res_t out_data;

    assign beat_acc    = in_ch.valid && buf_ready;
    assign in_ch.ready = buf_ready;

    smbs_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat_acc    (beat_acc),
        .start_req   (in_ch.start_req),
        .tx_byte     (in_ch.tx_byte),
        .msb_first   (in_ch.msb_first),
        .miso_level  (in_ch.miso_level),
        .res         (res)
    );

    smbs_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (beat_acc),
        .push_data  (res),
        .push_ready (buf_ready),
        .pop_valid  (out_ch.valid),
        .pop_ready  (out_ch.ready),
        .pop_data   (out_data)
    );

    assign out_ch.sclk_level = out_data.sclk_level;
    assign out_ch.mosi_level = out_data.mosi_level;
    assign out_ch.busy_res   = out_data.busy_res;
    assign out_ch.done_res   = out_data.done_res;
    assign out_ch.rx_byte    = out_data.rx_byte;

endmodule

`default_nettype wire

// ----- dv/spi_master_byte_shifter_tb.sv -----
`default_nettype none

module spi_master_byte_shifter_tb;
    import smbs_pkg::*;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned RANDOM_TICKS = 1800;
    localparam int unsigned TAIL_CYCLES  = 8;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_HIGH,
        ENG_LOW,
        ENG_TAIL
    } eng_phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] tx_byte;
        logic       msb_first;
        logic       miso_level;
    } tick_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    smbs_in_if  in_ch();
    smbs_out_if out_ch();

    spi_master_byte_shifter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    tick_beat_t  tick_stim_q[$];
    smbs_res_t   pin_expect_q[$];
    int unsigned ticks_queued;
    int unsigned ticks_taken;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned in_gap;
    int unsigned out_stall;
    logic        in_taken;
    logic        idle_on;

    logic [15:0] half_cfg;
    eng_phase_t  eng_phase;
    logic [3:0]  bits_done;
    logic [17:0] ph_timer;
    logic [7:0]  tx_sr;
    logic [7:0]  rx_sr;
    logic        msb_mode;

    always #1 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic phase_elapsed(input logic [17:0] lim);
        ph_timer = ph_timer + 18'd1;
        if (ph_timer >= lim)
        begin
            ph_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic smbs_res_t spi_engine_tick(input tick_beat_t b);
        smbs_res_t   r;
        logic [17:0] h;
        r = '0;
        h = (half_cfg == 16'd0) ? 18'd1 : {2'b00, half_cfg};
        if (eng_phase == ENG_IDLE && b.start_req)
        begin
            tx_sr     = b.tx_byte;
            msb_mode  = b.msb_first;
            rx_sr     = '0;
            bits_done = '0;
            ph_timer  = '0;
            eng_phase = ENG_HIGH;
        end
        case (eng_phase)
            ENG_HIGH:
            begin
                r.sclk_level = 1'b1;
                r.mosi_level = msb_mode ? tx_sr[7] : tx_sr[0];
                r.busy_res   = 1'b1;
                if (phase_elapsed(h))
                begin
                    rx_sr     = msb_mode ? {rx_sr[6:0], b.miso_level}
                                         : {b.miso_level, rx_sr[7:1]};
                    eng_phase = ENG_LOW;
                end
            end
            ENG_LOW:
            begin
                r.mosi_level = msb_mode ? tx_sr[7] : tx_sr[0];
                r.busy_res   = 1'b1;
                if (phase_elapsed(h))
                begin
                    tx_sr     = msb_mode ? (tx_sr << 1) : (tx_sr >> 1);
                    bits_done = bits_done + 4'd1;
                    eng_phase = (bits_done >= BIT_LIMIT) ? ENG_TAIL : ENG_HIGH;
                end
            end
            ENG_TAIL:
            begin
                r.busy_res = 1'b1;
                if (phase_elapsed({h[15:0], 2'b00}))
                begin
                    r.done_res = 1'b1;
                    r.rx_byte  = rx_sr;
                    eng_phase  = ENG_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_pin(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_tick(input logic st, input logic [7:0] tx, input logic msb,
                             input logic miso);
        tick_beat_t b;
        b.start_req  = st;
        b.tx_byte    = tx;
        b.msb_first  = msb;
        b.miso_level = miso;
        tick_stim_q.push_back(b);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || pin_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_half_period(input logic [15:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        half_cfg = v;
        cfg_wr_en <= 1'b0;
    endtask

    // drive input beats and output ready at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
            in_gap       <= 0;
            out_stall    <= 0;
        end
        else
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (in_gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    in_gap      <= in_gap - 1;
                end
                else if (tick_stim_q.size() > 0)
                begin
                    tick_beat_t b;
                    b = tick_stim_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.start_req  <= b.start_req;
                    in_ch.tx_byte    <= b.tx_byte;
                    in_ch.msb_first  <= b.msb_first;
                    in_ch.miso_level <= b.miso_level;
                    in_gap           <= idle_on ? pick_gap() : 0;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall    <= out_stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    out_stall <= pick_gap();
            end
        end
    end

    // check result beats, then predict from accepted input beats
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                if (pin_expect_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %0h", $time,
                             {out_ch.sclk_level, out_ch.mosi_level, out_ch.busy_res,
                              out_ch.done_res, out_ch.rx_byte});
                    mismatch_count++;
                end
                else
                begin
                    smbs_res_t want;
                    want = pin_expect_q.pop_front();
                    check_pin("sclk_level", 8'(want.sclk_level), 8'(out_ch.sclk_level));
                    check_pin("mosi_level", 8'(want.mosi_level), 8'(out_ch.mosi_level));
                    check_pin("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
                    check_pin("done_res", 8'(want.done_res), 8'(out_ch.done_res));
                    check_pin("rx_byte", want.rx_byte, out_ch.rx_byte);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                tick_beat_t b;
                b.start_req  = in_ch.start_req;
                b.tx_byte    = in_ch.tx_byte;
                b.msb_first  = in_ch.msb_first;
                b.miso_level = in_ch.miso_level;
                pin_expect_q.push_back(spi_engine_tick(b));
                ticks_taken++;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned random_ticks;
        int unsigned ph_idx;
        int unsigned pick;
        int unsigned start_pct;
        int unsigned n;
        logic [15:0] hp;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.start_req  = 1'b0;
        in_ch.tx_byte    = '0;
        in_ch.msb_first  = 1'b0;
        in_ch.miso_level = 1'b0;
        out_ch.ready     = 1'b0;
        ticks_queued     = 0;
        ticks_taken      = 0;
        mismatch_count   = 0;
        idle_on          = 1'b1;
        half_cfg         = HALF_PERIOD_RESET;
        eng_phase        = ENG_IDLE;
        bits_done        = '0;
        ph_timer         = '0;
        tx_sr            = '0;
        rx_sr            = '0;
        msb_mode         = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // idle outputs, then a start at the reset half period
        push_tick(1'b0, 8'hFF, 1'b1, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        push_tick(1'b1, 8'hA5, 1'b1, 1'b1);
        push_tick(1'b1, 8'h00, 1'b0, 1'b0);
        push_tick(1'b1, 8'hFF, 1'b0, 1'b1);
        // shrink to zero mid-transfer, hold start high through the done tick
        set_half_period(16'd0);
        for (int i = 0; i < 20; i++)
            push_tick(1'b1, 8'h3C, 1'b0, i[0]);

        random_ticks = 0;
        ph_idx       = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            pick = $urandom_range(0, 99);
            if (ph_idx == 0 || pick < 5)
                hp = 16'hFFFF;
            else if (pick < 12)
                hp = 16'd0;
            else if (pick < 17)
                hp = 16'($urandom_range(10, 300));
            else if (pick < 35)
                hp = 16'($urandom_range(4, 9));
            else
                hp = 16'($urandom_range(1, 3));
            set_half_period(hp);
            idle_on   = ($urandom_range(0, 3) != 0);
            start_pct = ($urandom_range(0, 4) == 0) ? 5 : 60;
            n         = $urandom_range(40, 160);
            repeat (n)
                push_tick($urandom_range(0, 99) < start_pct, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            random_ticks += n;
            ph_idx++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
